[rtl/dvw_pkg.sv]
// Shared types and constants of the disparity view warp block.
// Holds the pixel and window cell records and the gray conversion weights.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dvw_pkg;

    // Channel and field widths.
    localparam int PIX_W   = 8;
    localparam int SHIFT_W = 5;
    localparam int SUM_W   = 22;

    // Gray weights (B, G, R) and the rounding term of the 14-bit fixed point sum.
    localparam logic [SUM_W-1:0] W_BLUE  = 22'd1868;
    localparam logic [SUM_W-1:0] W_GREEN = 22'd9617;
    localparam logic [SUM_W-1:0] W_RED   = 22'd4899;
    localparam logic [SUM_W-1:0] ROUND   = 22'd8192;

    // Gray is the sum shifted by 14; the shift takes gray / 16, so 18 bits in all.
    localparam int SHIFT_POS = 18;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_rgb;

    // One pending pixel of the window.
    typedef struct packed {
        logic               valid;
        t_rgb               left;
        t_rgb               right;
        logic [SHIFT_W-1:0] shift;
    } t_cell;

    // What a chain reports about the pixel at its head.
    typedef struct packed {
        logic head_valid;
        logic next_valid;
        logic take;
        t_rgb pix;
    } t_head_stat;

endpackage

`default_nettype wire

[rtl/dvw_in_if.sv]
// Input pixel channel of the disparity view warp block.
// Carries valid, ready and the disparity, left and right pixels. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface dvw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] disp_blue;
    logic [7:0] disp_green;
    logic [7:0] disp_red;
    logic [7:0] left_blue;
    logic [7:0] left_green;
    logic [7:0] left_red;
    logic [7:0] right_blue;
    logic [7:0] right_green;
    logic [7:0] right_red;
    logic       row_end;

    modport source (
        output valid, disp_blue, disp_green, disp_red, left_blue, left_green, left_red,
               right_blue, right_green, right_red, row_end,
        input  ready
    );

    modport sink (
        input  valid, disp_blue, disp_green, disp_red, left_blue, left_green, left_red,
               right_blue, right_green, right_red, row_end,
        output ready
    );
endinterface

`default_nettype wire

[rtl/dvw_out_if.sv]
// Output pixel channel of the disparity view warp block.
// Carries valid, ready and the synthesized pixel. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface dvw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic       out_row_end;

    modport source (
        output valid, out_blue, out_green, out_red, out_row_end,
        input  ready
    );

    modport sink (
        input  valid, out_blue, out_green, out_red, out_row_end,
        output ready
    );
endinterface

`default_nettype wire

[rtl/dvw_cell.sv]
// One window cell: holds a pending pixel and passes it to its left neighbor.
// Depends on dvw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dvw_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire dvw_pkg::t_cell i_load_data,
    input  wire logic          i_shift,
    input  wire dvw_pkg::t_cell i_nbr,
    input  wire logic          i_zap,
    output dvw_pkg::t_cell     o_cell,
    output dvw_pkg::t_cell     o_fwd
);

    dvw_pkg::t_cell r_cell;
    dvw_pkg::t_cell n_cell;

    // A left pixel taken by the head leaves this cell blacked out.
    always_comb begin
        o_fwd = r_cell;
        if (i_zap) begin
            o_fwd.left = '0;
        end
    end

    // Load wins over the shift; otherwise the cell holds.
    always_comb begin
        n_cell = r_cell;
        if (i_load) begin
            n_cell = i_load_data;
        end else if (i_shift) begin
            n_cell = i_nbr;
        end
    end

    // Only the valid bit needs a reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell.valid <= n_cell.valid;
        end
        r_cell.left  <= n_cell.left;
        r_cell.right <= n_cell.right;
        r_cell.shift <= n_cell.shift;
    end

    assign o_cell = r_cell;

endmodule

`default_nettype wire

[rtl/dvw_chain.sv]
// Row of window cells with the head selection that forms one output pixel.
// The head pixel takes the left pixel shift cells ahead when that cell is
// occupied. Depends on dvw_pkg and dvw_cell.
`timescale 1ns / 1ps
`default_nettype none

module dvw_chain #(
    parameter int DEPTH = 17
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_emit,
    input  wire logic [DEPTH-1:0]        i_load,
    input  wire dvw_pkg::t_cell [DEPTH-1:0] i_load_data,
    output dvw_pkg::t_cell [DEPTH-1:0]   o_cells,
    output dvw_pkg::t_head_stat          o_stat
);

    dvw_pkg::t_cell [DEPTH-1:0] fwd;
    dvw_pkg::t_cell             sel;
    logic                       sel_hit;
    logic                       take;
    logic [DEPTH-1:0]           zap;
    dvw_pkg::t_rgb              pix;

    // Pick the cell that the head's shift points at.
    always_comb begin
        sel     = '0;
        sel_hit = 1'b0;
        for (int k = 0; k < DEPTH; k++) begin
            if (int'(o_cells[0].shift) == k) begin
                sel     = o_cells[k];
                sel_hit = 1'b1;
            end
        end
        take = sel_hit && sel.valid;
    end

    // Taken source is zeroed as it moves down one place.
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            zap[k] = i_emit && take && (int'(o_cells[0].shift) == k);
        end
    end

    // A warp pixel with zero blue, or a missing one, is filled from the right view.
    always_comb begin
        pix = take ? sel.left : '0;
        if (pix.blue == '0) begin
            pix = o_cells[0].right;
        end
    end

    assign o_stat.head_valid = o_cells[0].valid;
    assign o_stat.next_valid = o_cells[1].valid;
    assign o_stat.take       = take;
    assign o_stat.pix        = pix;

    // Cells; the last one is refilled with an empty entry on a shift.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        dvw_pkg::t_cell nbr;
        if (k == DEPTH - 1) begin : g_tail
            assign nbr = '0;
        end else begin : g_body
            assign nbr = fwd[k+1];
        end

        dvw_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (i_load[k]),
            .i_load_data (i_load_data[k]),
            .i_shift     (i_emit),
            .i_nbr       (nbr),
            .i_zap       (zap[k]),
            .o_cell      (o_cells[k]),
            .o_fwd       (fwd[k])
        );
    end

endmodule

`default_nettype wire

[rtl/disparity_view_warp.sv]
// Disparity view warp: one pixel accepted per cycle unless stalled; output pixel j is
// registered once pixel j+16 is in the window, and after a row end the flush chain
// emits the rest of the row, one per cycle unless the output stalls. A row end waits
// for a draining flush chain. The 17-cell window chain takes and emits once a cycle
// unless stalled. Synchronous active-low reset empties the window, flush chain and
// output register. Depends on dvw_pkg, dvw_in_if, dvw_out_if, dvw_chain and dvw_cell.
`timescale 1ns / 1ps
`default_nettype none

module disparity_view_warp #(
    parameter int WINDOW_DEPTH = 17
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dvw_in_if.sink    i_pix,
    dvw_out_if.source o_pix
);

    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    // Input stage: weighted products of the disparity and the pixels.
    logic                        r_s0_valid;
    logic [dvw_pkg::SUM_W-1:0]   r_pb;
    logic [dvw_pkg::SUM_W-1:0]   r_pg;
    logic [dvw_pkg::SUM_W-1:0]   r_pr;
    dvw_pkg::t_rgb               r_left;
    dvw_pkg::t_rgb               r_right;
    logic                        r_row_end;

    logic [CW-1:0]               r_cnt;
    logic [CW-1:0]               n_cnt;
    logic [CW-1:0]               wpos;

    logic                        r_out_valid;
    dvw_pkg::t_rgb               r_out;
    logic                        r_out_row_end;

    logic [dvw_pkg::SUM_W-1:0]   sum;
    dvw_pkg::t_cell              new_cell;

    logic                        m_full;
    logic                        f_busy;
    logic                        emit_ok;
    logic                        m_emit;
    logic                        f_emit;
    logic                        s0_move;
    logic                        append;
    logic                        flush;

    logic [WINDOW_DEPTH-1:0]     m_load;
    dvw_pkg::t_cell [WINDOW_DEPTH-1:0] m_load_data;
    dvw_pkg::t_cell [WINDOW_DEPTH-1:0] m_cells;
    dvw_pkg::t_head_stat         m_stat;

    logic [WINDOW_DEPTH-1:0]     f_load;
    dvw_pkg::t_cell [WINDOW_DEPTH-1:0] f_load_data;
    dvw_pkg::t_cell [WINDOW_DEPTH-1:0] f_cells;
    dvw_pkg::t_head_stat         f_stat;

    // Gray sum and the 1..16 shift of the staged pixel.
    assign sum = r_pb + r_pg + r_pr + dvw_pkg::ROUND;

    always_comb begin
        new_cell       = '0;
        new_cell.valid = 1'b1;
        new_cell.left  = r_left;
        new_cell.right = r_right;
        new_cell.shift = {1'b0, sum[dvw_pkg::SUM_W-1:dvw_pkg::SHIFT_POS]} + 5'd1;
    end

    // Flow control: the flush chain is older than the window and emits first.
    assign m_full  = (r_cnt == CW'(WINDOW_DEPTH));
    assign f_busy  = f_stat.head_valid;
    assign emit_ok = !r_out_valid || o_pix.ready;
    assign f_emit  = f_busy && emit_ok;
    assign m_emit  = m_full && !f_busy && emit_ok;
    assign s0_move = r_s0_valid && (r_row_end ? (!m_full && !f_busy) : (!m_full || m_emit));
    assign append  = s0_move && !r_row_end;
    assign flush   = s0_move && r_row_end;

    assign i_pix.ready = !r_s0_valid || s0_move;

    // The window appends behind its last pixel, one place lower when it shifts.
    assign wpos = m_emit ? (r_cnt - CW'(1)) : r_cnt;

    always_comb begin
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
            m_load[k]      = flush || (append && (int'(wpos) == k));
            m_load_data[k] = flush ? '0 : new_cell;
            f_load[k]      = flush;
            if (k < int'(r_cnt)) begin
                f_load_data[k] = m_cells[k];
            end else if (k == int'(r_cnt)) begin
                f_load_data[k] = new_cell;
            end else begin
                f_load_data[k] = '0;
            end
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (flush) begin
            n_cnt = '0;
        end else begin
            n_cnt = r_cnt + CW'(append) - CW'(m_emit);
        end
    end

    dvw_chain #(
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_emit      (m_emit),
        .i_load      (m_load),
        .i_load_data (m_load_data),
        .o_cells     (m_cells),
        .o_stat      (m_stat)
    );

    dvw_chain #(
        .DEPTH (WINDOW_DEPTH)
    ) u_flush (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_emit      (f_emit),
        .i_load      (f_load),
        .i_load_data (f_load_data),
        .o_cells     (f_cells),
        .o_stat      (f_stat)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_pix.valid && i_pix.ready) begin
                r_s0_valid <= 1'b1;
            end else if (s0_move) begin
                r_s0_valid <= 1'b0;
            end
            if (f_emit || m_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
            r_cnt <= n_cnt;
        end
    end

    // Input stage payload.
    always_ff @(posedge i_clk) begin
        if (i_pix.valid && i_pix.ready) begin
            r_pb          <= dvw_pkg::SUM_W'(i_pix.disp_blue) * dvw_pkg::W_BLUE;
            r_pg          <= dvw_pkg::SUM_W'(i_pix.disp_green) * dvw_pkg::W_GREEN;
            r_pr          <= dvw_pkg::SUM_W'(i_pix.disp_red) * dvw_pkg::W_RED;
            r_left.blue   <= i_pix.left_blue;
            r_left.green  <= i_pix.left_green;
            r_left.red    <= i_pix.left_red;
            r_right.blue  <= i_pix.right_blue;
            r_right.green <= i_pix.right_green;
            r_right.red   <= i_pix.right_red;
            r_row_end     <= i_pix.row_end;
        end
    end

    // Output register payload; only the flush chain ends a row.
    always_ff @(posedge i_clk) begin
        if (f_emit) begin
            r_out         <= f_stat.pix;
            r_out_row_end <= !f_stat.next_valid;
        end else if (m_emit) begin
            r_out         <= m_stat.pix;
            r_out_row_end <= 1'b0;
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.out_blue    = r_out.blue;
    assign o_pix.out_green   = r_out.green;
    assign o_pix.out_red     = r_out.red;
    assign o_pix.out_row_end = r_out_row_end;

    // The pending count never passes the window depth.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(WINDOW_DEPTH))
        else $error("window count beyond depth");

    // A full window has its last cell occupied.
    a_full_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_full |-> m_cells[WINDOW_DEPTH-1].valid)
        else $error("full window with empty tail cell");

    // A full window always finds the source of its head inside.
    a_full_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_emit |-> m_stat.take)
        else $error("window head source outside a full window");

    // A row end hands the row to the flush chain.
    a_flush_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flush |=> f_busy)
        else $error("row end left the flush chain empty");

    // The last pixel of a row leaves the flush chain empty.
    a_flush_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (f_emit && !f_stat.next_valid) |=> !f_busy)
        else $error("flush chain busy after its row end");

    // The flush chain holds its row without gaps, so an empty head means an empty chain.
    a_flush_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !f_cells[0].valid |-> !f_cells[1].valid)
        else $error("flush chain holds a pixel behind an empty head");

endmodule

`default_nettype wire
